// ===== src/tbr_pkg.sv =====
`default_nettype none

package tbr_pkg;

    localparam int unsigned IN_W    = 16;
    localparam int unsigned REF_W   = 16;
    localparam int unsigned SLOPE_W = 24;
    localparam int unsigned ALPHA_W = 16;
    localparam int unsigned TURB_W  = 24;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned IDX_W   = 2;

    // magnitude of slope * excess, and divider step count
    localparam int unsigned PROD_W  = 46;
    localparam int unsigned MAG_W   = 45;
    localparam int unsigned CNT_W   = 6;

    localparam logic [IDX_W-1:0] REG_REFERENCE = 2'd0;
    localparam logic [IDX_W-1:0] REG_SLOPE     = 2'd1;
    localparam logic [IDX_W-1:0] REG_SMOOTH    = 2'd2;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_init;
        logic div_step;
        logic fix;
        logic mul_new;
        logic mul_old;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/tbr_ctrl.sv =====
`default_nettype none

module tbr_ctrl (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_ready,
    input  wire          i_out_ready,
    input  tbr_pkg::t_sts i_sts,
    output tbr_pkg::t_cmd o_cmd
);
    import tbr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DINIT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIX   = 3'd4;
    localparam logic [2:0] S_MNEW  = 3'd5;
    localparam logic [2:0] S_MOLD  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             accept;
    logic             out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !i_sts.out_full || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = CNT_W'(MAG_W - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_MNEW;
            end
            S_MNEW: begin
                o_cmd.mul_new = 1'b1;
                n_state       = S_MOLD;
            end
            S_MOLD: begin
                o_cmd.mul_old = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input taken while busy");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_FIX))
        else $error("divider did not finish on count");

    a_finish_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> i_sts.out_full)
        else $error("result beat not loaded");

endmodule

`default_nettype wire

// ===== src/tbr_datapath.sv =====
`default_nettype none

module tbr_datapath (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  tbr_pkg::t_cmd                 i_cmd,
    output tbr_pkg::t_sts                 o_sts,
    input  wire                           i_cfg_wr_en,
    input  wire [tbr_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire [tbr_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire [tbr_pkg::IN_W-1:0]       i_dark_level,
    input  wire [tbr_pkg::IN_W-1:0]       i_lit_level,
    input  wire                           i_out_ready,
    output logic                          o_out_valid,
    output logic [tbr_pkg::IN_W-1:0]      o_dark_times_ten,
    output logic [tbr_pkg::IN_W-1:0]      o_signal_times_ten,
    output logic [tbr_pkg::TURB_W-1:0]    o_turbidity,
    output logic                          o_ground_error
);
    import tbr_pkg::*;

    logic [REF_W-1:0]          r_ref;
    logic signed [SLOPE_W-1:0] r_slope;
    logic [ALPHA_W-1:0]        r_alpha;

    logic                      r_first;
    logic signed [31:0]        r_prev;
    logic [IN_W-1:0]           r_held;

    logic [IN_W-1:0]           r_dark10;
    logic [IN_W-1:0]           r_sig10;
    logic                      r_gnd;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_neg;
    logic [MAG_W-1:0]          r_quo;
    logic [19:0]               r_rem;
    logic signed [31:0]        r_raw;
    logic signed [48:0]        r_p_new;
    logic signed [48:0]        r_p_old;
    logic                      r_out_valid;

    logic [IN_W-1:0]           diff;
    logic [19:0]               dark10_full;
    logic [19:0]               diff10_full;
    logic [19:0]               held10;
    logic [19:0]               den;
    logic signed [21:0]        excess;
    logic [PROD_W-1:0]         prod_abs;
    logic [21:0]               trial;
    logic                      fits;
    logic signed [46:0]        q_ext;
    logic signed [46:0]        q_signed;
    logic signed [31:0]        raw_div;
    logic [ALPHA_W-1:0]        alpha_c;
    logic [ALPHA_W-1:0]        beta;
    logic signed [49:0]        sum;
    logic signed [49:0]        sum_sh;
    logic signed [31:0]        blend;
    logic signed [31:0]        smoothed;
    logic [TURB_W-1:0]         turb;

    assign diff        = i_lit_level - i_dark_level;
    assign dark10_full = 20'(i_dark_level) * 20'd10;
    assign diff10_full = 20'(diff) * 20'd10;
    assign held10      = 20'(r_held) * 20'd10;
    assign den         = {r_ref, 4'b0000};
    assign excess      = $signed({2'b00, held10}) - $signed({2'b00, den});
    assign prod_abs    = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : r_prod;

    // one restoring step per cycle
    assign trial = {1'b0, r_rem, r_quo[MAG_W-1]} - {2'b00, den};
    assign fits  = !trial[21];

    // floor quotient with saturation to 32 bits
    always_comb begin
        q_ext = $signed({2'b00, r_quo});
        if (r_neg) begin
            q_signed = -(q_ext + 47'(r_rem != '0));
        end else begin
            q_signed = q_ext;
        end
        if (q_signed[46:31] != {16{q_signed[46]}}) begin
            raw_div = q_signed[46] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            raw_div = q_signed[31:0];
        end
    end

    assign alpha_c = (r_alpha > 16'd32768) ? 16'd32768 : r_alpha;
    assign beta    = 16'd32768 - alpha_c;

    always_comb begin
        sum    = 50'(r_p_new) + 50'(r_p_old);
        sum_sh = sum >>> 15;
        if (sum_sh[49:31] != {19{sum_sh[49]}}) begin
            blend = sum_sh[49] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            blend = sum_sh[31:0];
        end
        smoothed = r_first ? r_raw : blend;
        if (smoothed[31]) begin
            turb = '0;
        end else if (smoothed[30:24] != '0) begin
            turb = '1;
        end else begin
            turb = smoothed[TURB_W-1:0];
        end
    end

    // configuration and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref       <= 16'd10000;
            r_slope     <= 24'sd256;
            r_alpha     <= 16'd32768;
            r_first     <= 1'b1;
            r_prev      <= '0;
            r_held      <= 16'd16;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_REFERENCE: r_ref   <= i_cfg_data[REF_W-1:0];
                    REG_SLOPE:     r_slope <= i_cfg_data[SLOPE_W-1:0];
                    REG_SMOOTH:    r_alpha <= i_cfg_data[ALPHA_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_in && (i_lit_level > i_dark_level)) begin
                r_held <= diff;
            end
            if (i_cmd.finish) begin
                r_prev      <= smoothed;
                r_first     <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_dark10 <= dark10_full[19:4];
            if (i_lit_level > i_dark_level) begin
                r_sig10 <= diff10_full[19:4];
                r_gnd   <= 1'b0;
            end else begin
                r_sig10 <= r_ref;
                r_gnd   <= 1'b1;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= r_slope * excess;
        end
        if (i_cmd.div_init) begin
            r_neg <= r_prod[PROD_W-1];
            r_quo <= prod_abs[MAG_W-1:0];
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= fits ? trial[19:0] : {r_rem[18:0], r_quo[MAG_W-1]};
            r_quo <= {r_quo[MAG_W-2:0], fits};
        end
        if (i_cmd.fix) begin
            if (r_ref == '0) begin
                if (r_slope == '0) begin
                    r_raw <= '0;
                end else begin
                    r_raw <= r_slope[SLOPE_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end
            end else begin
                r_raw <= raw_div;
            end
        end
        if (i_cmd.mul_new) begin
            r_p_new <= $signed({1'b0, alpha_c}) * r_raw;
        end
        if (i_cmd.mul_old) begin
            r_p_old <= $signed({1'b0, beta}) * r_prev;
        end
        if (i_cmd.finish) begin
            o_dark_times_ten   <= r_dark10;
            o_signal_times_ten <= r_sig10;
            o_ground_error     <= r_gnd;
            o_turbidity        <= turb;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.out_full = r_out_valid;

endmodule

`default_nettype wire

// ===== src/turbidity_ratio_smoother_unit.sv =====
`default_nettype none

// Turbidity ratio smoother. Each input beat carries a dark and a lit reading
// (Q12.4 counts) and yields one result beat: dark and signal times ten, the
// ground error flag and the smoothed turbidity (unsigned Q16.8, clamped at
// zero). The restoring divider forms slope*(signal*10/reference-1) one
// quotient bit per cycle; a new item is taken the cycle after the previous
// result has been loaded into the output register, and a result beat held
// back by the receiver holds the next item at its last step. Configuration
// writes (reference, slope, smoothing factor) are taken at any cycle but
// belong between items.

module turbidity_ratio_smoother_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_wr_en,
    input  wire [tbr_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire [tbr_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire [tbr_pkg::IN_W-1:0]       i_dark_level,
    input  wire [tbr_pkg::IN_W-1:0]       i_lit_level,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [tbr_pkg::IN_W-1:0]      o_dark_times_ten,
    output logic [tbr_pkg::IN_W-1:0]      o_signal_times_ten,
    output logic [tbr_pkg::TURB_W-1:0]    o_turbidity,
    output logic                          o_ground_error
);
    import tbr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tbr_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_dark_level       (i_dark_level),
        .i_lit_level        (i_lit_level),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_dark_times_ten   (o_dark_times_ten),
        .o_signal_times_ten (o_signal_times_ten),
        .o_turbidity        (o_turbidity),
        .o_ground_error     (o_ground_error)
    );

endmodule

`default_nettype wire
